@@ design/fbsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsc_pkg
// Shared types, constants and float helpers for the frustum box/sphere culler.
// ----------------------------------------------------------------------------
package fbsc_pkg;

	localparam int MAX_PLANES = 6;
	localparam int PLANE_AW   = $clog2(MAX_PLANES);
	localparam int PLANE_CW   = $clog2(MAX_PLANES + 1);

	localparam logic [2:0]  PLANE_COUNT_RESET = 3'd6;
	localparam logic [31:0] MARGIN_RESET      = 32'h4248_0000;
	localparam logic [31:0] FP_ZERO           = 32'h0000_0000;
	localparam logic [31:0] FP_QNAN           = 32'h7FC0_0000;

	typedef enum logic [2:0] {
		CMD_LOAD       = 3'd0,
		CMD_FULL       = 3'd1,
		CMD_QUICK      = 3'd2,
		CMD_SPHERE     = 3'd3,
		CMD_UPDATE     = 3'd4,
		CMD_ENABLE_ALL = 3'd5
	} cmd_t;

	typedef enum logic [0:0] {
		CFG_PLANE_COUNT    = 1'b0,
		CFG_OUTSIDE_MARGIN = 1'b1
	} cfg_reg_t;

	typedef enum logic [0:0] {
		FP_ADD = 1'b0,
		FP_MUL = 1'b1
	} fp_op_t;

	typedef enum logic [1:0] {
		PH_NEAR   = 2'd0,
		PH_FAR    = 2'd1,
		PH_SPHERE = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PLANE,
		ST_READ,
		ST_ISSUE,
		ST_WAIT,
		ST_DECIDE,
		ST_DONE
	} state_t;

	localparam logic [1:0] VERDICT_OUTSIDE = 2'd0;
	localparam logic [1:0] VERDICT_CROSS   = 2'd1;
	localparam logic [1:0] VERDICT_INSIDE  = 2'd2;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [2:0]  plane_slot;
		logic [31:0] box_min_x;
		logic [31:0] box_min_y;
		logic [31:0] box_min_z;
		logic [31:0] box_max_x;
		logic [31:0] box_max_y;
		logic [31:0] box_max_z;
		logic [31:0] vec_x;
		logic [31:0] vec_y;
		logic [31:0] vec_z;
		logic [31:0] scalar;
	} item_t;

	typedef struct packed {
		logic [1:0] verdict;
		logic [5:0] enable_bits;
	} result_t;

	typedef struct packed {
		logic [31:0] nx;
		logic [31:0] ny;
		logic [31:0] nz;
		logic [31:0] distance;
		logic [2:0]  signs;
	} plane_t;

	function automatic logic fp_is_nan(input logic [31:0] a);
		return (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
	endfunction

	// Total-order key; the caller handles NaN and the two zeros.
	function automatic logic [31:0] fp_key(input logic [31:0] a);
		return a[31] ? ~a : (a | 32'h8000_0000);
	endfunction

	function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
		logic both_zero;
		both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
		return !fp_is_nan(a) && !fp_is_nan(b) && !both_zero && (fp_key(a) > fp_key(b));
	endfunction

	function automatic logic fp_le(input logic [31:0] a, input logic [31:0] b);
		logic both_zero;
		both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
		return !fp_is_nan(a) && !fp_is_nan(b) && (both_zero || (fp_key(a) <= fp_key(b)));
	endfunction

endpackage

@@ design/frustum_box_sphere_culler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frustum_box_sphere_culler
// Plane-table culler for offset boxes and spheres, one word in, one word out.
// ----------------------------------------------------------------------------
// The block takes one word at a time. Loads, enable-all and unknown commands
// go straight from idle to the done state. A test walks the enabled planes in
// order: each plane costs a RAM read and nine dependent float operations on
// one shared three-stage add/multiply unit (six for a sphere); a full test
// may walk the table twice. The word is then held in an output register, so a
// stalled result does not delay the next test beyond that register. Plane
// entries read before they were loaded give undefined verdicts.
module frustum_box_sphere_culler import fbsc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  item_t       item,
	output logic        result_valid,
	input  logic        result_stall,
	output result_t     result,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	state_t state_q, state_d;

	logic [2:0]            plane_count_q;
	logic [31:0]           margin_q;
	logic [MAX_PLANES-1:0] mask_q;
	item_t                 item_q;
	phase_t                phase_q;
	logic [PLANE_CW-1:0]   plane_q;
	logic [3:0]            uop_q;
	logic [1:0]            wait_q;
	logic [31:0]           cx_q, cy_q, cz_q, t_q, u_q;
	logic [1:0]            verdict_q;
	logic                  result_valid_q;
	result_t               result_q;

	logic [PLANE_CW-1:0] n_planes;
	logic                accept;
	logic                plane_end, plane_on;
	logic                far;
	logic [31:0]         sel_x, sel_y, sel_z;
	fp_op_t              fpu_op;
	logic [31:0]         fpu_a, fpu_b, fpu_result;
	plane_t              rd_plane, wr_plane;
	logic                ram_we;
	logic [PLANE_AW-1:0] rd_addr;

	assign cfg_ready    = 1'b1;
	assign item_stall   = (state_q != ST_IDLE);
	assign accept       = item_valid && !item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign n_planes  = (plane_count_q > 3'(MAX_PLANES)) ? PLANE_CW'(MAX_PLANES)
	                                                    : PLANE_CW'(plane_count_q);
	assign plane_end = (plane_q >= n_planes);
	assign rd_addr   = plane_q[PLANE_AW-1:0];
	assign plane_on  = mask_q[rd_addr];

	// Plane table.
	assign ram_we   = accept && (item.cmd == CMD_LOAD) &&
	                  (item.plane_slot < 3'(MAX_PLANES));
	assign wr_plane = '{nx: item.vec_x, ny: item.vec_y, nz: item.vec_z,
	                    distance: item.scalar,
	                    signs: {fp_le(FP_ZERO, item.vec_z), fp_le(FP_ZERO, item.vec_y),
	                            fp_le(FP_ZERO, item.vec_x)}};

	fbsc_ram #(
		.WIDTH ($bits(plane_t)),
		.DEPTH (MAX_PLANES)
	) u_plane_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (item.plane_slot[PLANE_AW-1:0]),
		.wr_data (wr_plane),
		.rd_en   (state_q == ST_PLANE),
		.rd_addr (rd_addr),
		.rd_data (rd_plane)
	);

	// The near corner takes the minimum where the normal is non-negative.
	assign far   = (phase_q != PH_NEAR);
	assign sel_x = (rd_plane.signs[0] == far) ? item_q.box_max_x : item_q.box_min_x;
	assign sel_y = (rd_plane.signs[1] == far) ? item_q.box_max_y : item_q.box_min_y;
	assign sel_z = (rd_plane.signs[2] == far) ? item_q.box_max_z : item_q.box_min_z;

	always_comb begin
		case (uop_q)
			4'd0: begin fpu_op = FP_ADD; fpu_a = sel_x; fpu_b = item_q.vec_x; end
			4'd1: begin fpu_op = FP_ADD; fpu_a = sel_y; fpu_b = item_q.vec_y; end
			4'd2: begin fpu_op = FP_ADD; fpu_a = sel_z; fpu_b = item_q.vec_z; end
			4'd3: begin fpu_op = FP_MUL; fpu_a = cz_q;  fpu_b = rd_plane.nz;  end
			4'd4: begin fpu_op = FP_MUL; fpu_a = cx_q;  fpu_b = rd_plane.nx;  end
			4'd5: begin fpu_op = FP_ADD; fpu_a = t_q;   fpu_b = u_q;          end
			4'd6: begin fpu_op = FP_MUL; fpu_a = cy_q;  fpu_b = rd_plane.ny;  end
			4'd7: begin fpu_op = FP_ADD; fpu_a = t_q;   fpu_b = u_q;          end
			4'd8: begin
				fpu_op = FP_ADD;
				fpu_a  = t_q;
				fpu_b  = {~rd_plane.distance[31], rd_plane.distance[30:0]};
			end
			default: begin fpu_op = FP_ADD; fpu_a = FP_ZERO; fpu_b = FP_ZERO; end
		endcase
	end

	fbsc_fpu u_fpu (
		.clk    (clk),
		.op     (fpu_op),
		.a      (fpu_a),
		.b      (fpu_b),
		.result (fpu_result)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.cmd == CMD_FULL || item.cmd == CMD_QUICK ||
					    item.cmd == CMD_SPHERE || item.cmd == CMD_UPDATE) begin
						state_d = ST_PLANE;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_PLANE: begin
				if (plane_end) begin
					if (phase_q == PH_NEAR && item_q.cmd == CMD_FULL) begin
						state_d = ST_PLANE;
					end else begin
						state_d = ST_DONE;
					end
				end else if (plane_on) begin
					state_d = ST_READ;
				end
			end
			ST_READ:  state_d = ST_ISSUE;
			ST_ISSUE: state_d = ST_WAIT;
			ST_WAIT: begin
				if (wait_q == 2'd0) begin
					state_d = (uop_q == 4'd8) ? ST_DECIDE : ST_ISSUE;
				end
			end
			ST_DECIDE: begin
				state_d = ST_PLANE;
				case (phase_q)
					PH_NEAR: if (fp_gt(t_q, margin_q)) state_d = ST_DONE;
					PH_FAR: begin
						if (item_q.cmd == CMD_FULL && fp_gt(t_q, FP_ZERO)) begin
							state_d = ST_DONE;
						end
					end
					PH_SPHERE: if (!fp_le(t_q, item_q.scalar)) state_d = ST_DONE;
					default: state_d = ST_PLANE;
				endcase
			end
			ST_DONE: begin
				if (!result_valid_q || !result_stall) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration, enable mask and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_count_q  <= PLANE_COUNT_RESET;
			margin_q       <= MARGIN_RESET;
			mask_q         <= '1;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PLANE_COUNT:    plane_count_q <= cfg_data[2:0];
					CFG_OUTSIDE_MARGIN: margin_q      <= cfg_data;
					default:            margin_q      <= margin_q;
				endcase
			end
			if (accept && item.cmd == CMD_ENABLE_ALL) begin
				mask_q <= '1;
			end
			if (state_q == ST_DECIDE && phase_q == PH_FAR && item_q.cmd == CMD_UPDATE &&
			    fp_le(t_q, FP_ZERO)) begin
				mask_q[rd_addr] <= 1'b0;
			end
			if (state_q == ST_DONE && (!result_valid_q || !result_stall)) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the plane walk.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					item_q    <= item;
					plane_q   <= '0;
					verdict_q <= VERDICT_OUTSIDE;
					if (item.cmd == CMD_SPHERE) begin
						phase_q <= PH_SPHERE;
					end else if (item.cmd == CMD_UPDATE) begin
						phase_q <= PH_FAR;
					end else begin
						phase_q <= PH_NEAR;
					end
				end
			end
			ST_PLANE: begin
				if (plane_end) begin
					plane_q <= '0;
					case (phase_q)
						PH_NEAR: begin
							verdict_q <= VERDICT_CROSS;
							phase_q   <= PH_FAR;
						end
						PH_FAR: begin
							verdict_q <= (item_q.cmd == CMD_FULL) ? VERDICT_INSIDE
							                                       : VERDICT_OUTSIDE;
						end
						default: verdict_q <= VERDICT_CROSS;
					endcase
				end else if (!plane_on) begin
					plane_q <= plane_q + 1'b1;
				end
			end
			ST_READ: begin
				if (phase_q == PH_SPHERE) begin
					cx_q  <= item_q.vec_x;
					cy_q  <= item_q.vec_y;
					cz_q  <= item_q.vec_z;
					uop_q <= 4'd3;
				end else begin
					uop_q <= 4'd0;
				end
			end
			ST_ISSUE: wait_q <= 2'd1;
			ST_WAIT: begin
				if (wait_q == 2'd0) begin
					case (uop_q)
						4'd0:    cx_q <= fpu_result;
						4'd1:    cy_q <= fpu_result;
						4'd2:    cz_q <= fpu_result;
						4'd4:    u_q  <= fpu_result;
						4'd6:    u_q  <= fpu_result;
						default: t_q  <= fpu_result;
					endcase
					uop_q <= uop_q + 4'd1;
				end else begin
					wait_q <= wait_q - 2'd1;
				end
			end
			ST_DECIDE: begin
				plane_q <= plane_q + 1'b1;
				if (phase_q == PH_FAR && item_q.cmd == CMD_FULL) begin
					verdict_q <= VERDICT_CROSS;
				end else begin
					verdict_q <= VERDICT_OUTSIDE;
				end
			end
			ST_DONE: begin
				if (!result_valid_q || !result_stall) begin
					result_q.verdict     <= verdict_q;
					result_q.enable_bits <= 6'(mask_q);
				end
			end
			default: wait_q <= wait_q;
		endcase
	end

	// A result is only raised out of the done state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result raised outside the done state");

	// Enable bits are only ever set back by an enable-all command.
	assert property (@(posedge clk) disable iff (!arst_n)
		((mask_q & ~$past(mask_q)) != '0) |->
			$past(accept && item.cmd == CMD_ENABLE_ALL))
		else $error("enable bit set without enable-all");

	// The read state is only entered for enabled planes in range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (plane_on && !plane_end))
		else $error("disabled or out-of-range plane fetched");

endmodule

@@ design/fbsc_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsc_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module fbsc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ design/fbsc_fpu.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsc_fpu
// Three-stage single-precision add/multiply with round to nearest even.
// ----------------------------------------------------------------------------
module fbsc_fpu import fbsc_pkg::*; (
	input  logic        clk,
	input  fp_op_t      op,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] result
);

	// Stage 1: exact product or aligned sum. Value is m * 2^(e - 127 - 46).
	logic              sign_s1, nan_s1, inf_s1;
	logic signed [11:0] e_s1;
	logic [47:0]       m_s1;

	logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
	logic [7:0]  ea, eb;
	logic [23:0] siga, sigb;
	logic        swap;
	logic [31:0] big, sml;
	logic [7:0]  e_big, e_sml, d;
	logic [23:0] sig_big, sig_sml;
	logic [26:0] sm27, bs;
	logic [27:0] sum28;
	logic        c_sign, c_nan, c_inf;
	logic signed [11:0] c_e;
	logic [47:0] c_m;

	always_comb begin
		nan_a  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
		nan_b  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
		inf_a  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
		inf_b  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
		zero_a = (a[30:0] == 31'd0);
		zero_b = (b[30:0] == 31'd0);
		ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
		eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
		siga   = {a[30:23] != 8'd0, a[22:0]};
		sigb   = {b[30:23] != 8'd0, b[22:0]};

		swap    = b[30:0] > a[30:0];
		big     = swap ? b : a;
		sml     = swap ? a : b;
		e_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
		e_sml   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
		sig_big = {big[30:23] != 8'd0, big[22:0]};
		sig_sml = {sml[30:23] != 8'd0, sml[22:0]};
		d       = e_big - e_sml;
		sm27    = {sig_sml, 3'b000};
		if (d >= 8'd27) begin
			bs = {26'd0, |sm27};
		end else begin
			bs = (sm27 >> d) | {26'd0, |(sm27 & ~(27'h7FF_FFFF << d))};
		end
		if (big[31] == sml[31]) begin
			sum28 = {1'b0, sig_big, 3'b000} + {1'b0, bs};
		end else begin
			sum28 = {1'b0, sig_big, 3'b000} - {1'b0, bs};
		end

		if (op == FP_MUL) begin
			c_nan  = nan_a | nan_b | (inf_a & zero_b) | (zero_a & inf_b);
			c_inf  = inf_a | inf_b;
			c_sign = a[31] ^ b[31];
			c_m    = siga * sigb;
			c_e    = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd127;
		end else begin
			c_nan  = nan_a | nan_b | (inf_a & inf_b & (a[31] != b[31]));
			c_inf  = inf_a | inf_b;
			c_sign = inf_a ? a[31] : (inf_b ? b[31] : big[31]);
			c_m    = {sum28, 20'd0};
			c_e    = $signed({4'd0, e_big});
		end
	end

	always_ff @(posedge clk) begin
		sign_s1 <= c_sign;
		nan_s1  <= c_nan;
		inf_s1  <= c_inf;
		e_s1    <= c_e;
		m_s1    <= c_m;
	end

	// Stage 2: leading-one search and shift amount.
	logic              sign_s2, nan_s2, inf_s2, zero_s2;
	logic [47:0]       m_s2;
	logic signed [11:0] r_s2;
	logic [9:0]        base_s2;

	logic [5:0]         lead;
	logic signed [11:0] e1, c_r;
	logic [9:0]         c_base;

	always_comb begin
		lead = 6'd0;
		for (int i = 0; i < 48; i++) begin
			if (m_s1[i]) begin
				lead = 6'(i);
			end
		end
		e1 = e_s1 + $signed({6'd0, lead}) - 12'sd46;
		if (e1 >= 12'sd1) begin
			c_r    = $signed({6'd0, lead}) - 12'sd23;
			c_base = 10'(e1 - 12'sd1);
		end else begin
			c_r    = $signed({6'd0, lead}) - 12'sd22 - e1;
			c_base = 10'd0;
		end
	end

	always_ff @(posedge clk) begin
		sign_s2 <= sign_s1;
		nan_s2  <= nan_s1;
		inf_s2  <= inf_s1;
		zero_s2 <= (m_s1 == 48'd0);
		m_s2    <= m_s1;
		r_s2    <= c_r;
		base_s2 <= c_base;
	end

	// Stage 3: shift, round and pack (feeds the caller's register).
	logic [49:0] v, sh, lost_mask;
	logic [5:0]  rr;
	logic [23:0] sig;
	logic        grd, stk, inc;
	logic [33:0] packed_sum;

	always_comb begin
		v         = {m_s2, 2'b00};
		rr        = (r_s2 > 12'sd50) ? 6'd50 : 6'(r_s2);
		sh        = v >> rr;
		lost_mask = ~({50{1'b1}} << rr);
		if (r_s2 < 12'sd0) begin
			sig = 24'(m_s2 << 6'(-r_s2));
			grd = 1'b0;
			stk = 1'b0;
		end else begin
			sig = sh[25:2];
			grd = sh[1];
			stk = sh[0] | (|(v & lost_mask));
		end
		inc        = grd & (stk | sig[0]);
		packed_sum = {1'b0, base_s2, 23'd0} + {10'd0, sig} + {33'd0, inc};
		if (nan_s2) begin
			result = FP_QNAN;
		end else if (inf_s2 || packed_sum >= 34'h0_7F80_0000) begin
			result = {sign_s2, 31'h7F80_0000};
		end else if (zero_s2) begin
			result = {sign_s2, 31'd0};
		end else begin
			result = {sign_s2, packed_sum[30:0]};
		end
	end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the frustum box/sphere culler. A single-precision
// plane model predicts each verdict and enable mask. Directed words cover the
// corner cases, then random words run through phases of sender and receiver
// idling with several register settings.
// ----------------------------------------------------------------------------
module tb;
	import fbsc_pkg::*;

	localparam logic [2:0] CMD_SPARE_A = 3'd6;
	localparam logic [2:0] CMD_SPARE_B = 3'd7;
	localparam int WATCHDOG_LIMIT = 8000;

	// Single-precision helpers. A double holds every float product exactly and
	// rounds sums so that a second rounding to single is still correct.
	function automatic real sp_to_real(input logic [31:0] b);
		logic [63:0] d;
		if (b[30:23] == 8'd0) begin
			sp_to_real = (b[31] ? -1.0 : 1.0) * real'(b[22:0]) * (2.0 ** -149);
			return sp_to_real;
		end
		d[63] = b[31];
		d[62:52] = (b[30:23] == 8'hFF) ? 11'h7FF : 11'(b[30:23]) - 11'd127 + 11'd1023;
		d[51:0] = {b[22:0], 29'd0};
		return $bitstoreal(d);
	endfunction

	function automatic logic [31:0] real_to_sp(input real r);
		logic [63:0] d;
		longint unsigned sig, kept, rem, half;
		int fe, sh;
		logic sgn;
		d = $realtobits(r);
		sgn = d[63];
		if (d[62:52] == 11'h7FF)
			return (d[51:0] != 0) ? {sgn, 31'h7FC0_0000} : {sgn, 8'hFF, 23'd0};
		if (d[62:52] == 11'd0)
			return {sgn, 31'd0};
		fe = int'(d[62:52]) - 1023 + 127;
		sig = {12'd1, d[51:0]};
		sh = (fe >= 1) ? 29 : 29 + 1 - fe;
		if (sh > 60)
			return {sgn, 31'd0};
		kept = sig >> sh;
		rem = sig & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && kept[0]))
			kept = kept + 1;
		if (fe < 1)
			return {sgn, 31'(kept)};
		if (kept == (64'd1 << 24)) begin
			kept = kept >> 1;
			fe = fe + 1;
		end
		if (fe >= 255)
			return {sgn, 8'hFF, 23'd0};
		return {sgn, 8'(fe), kept[22:0]};
	endfunction

	function automatic real sp_round(input real r);
		return sp_to_real(real_to_sp(r));
	endfunction

	class culler_scoreboard;
		logic [31:0] nx[MAX_PLANES], ny[MAX_PLANES], nz[MAX_PLANES];
		logic [31:0] distance[MAX_PLANES];
		logic [2:0] signs[MAX_PLANES];
		logic [5:0] mask;
		logic [2:0] count;
		logic [31:0] margin;
		result_t awaited[$];
		int errors;

		function new();
			mask = 6'h3F;
			count = PLANE_COUNT_RESET;
			margin = MARGIN_RESET;
			errors = 0;
		endfunction

		function void set_reg(input cfg_reg_t idx, input logic [31:0] data);
			if (idx == CFG_PLANE_COUNT)
				count = data[2:0];
			else
				margin = data;
		endfunction

		function real plane_dist(input int p, input real x, input real y, input real z);
			real t, u;
			t = sp_round(z * sp_to_real(nz[p]));
			u = sp_round(x * sp_to_real(nx[p]));
			t = sp_round(t + u);
			u = sp_round(y * sp_to_real(ny[p]));
			t = sp_round(t + u);
			return sp_round(t - sp_to_real(distance[p]));
		endfunction

		function real corner_dist(input int p, input item_t it, input bit far_side);
			real c[3];
			logic [31:0] lo[3], hi[3], off[3];
			lo = '{it.box_min_x, it.box_min_y, it.box_min_z};
			hi = '{it.box_max_x, it.box_max_y, it.box_max_z};
			off = '{it.vec_x, it.vec_y, it.vec_z};
			for (int k = 0; k < 3; k++)
				c[k] = sp_round(sp_to_real((signs[p][k] == far_side) ? hi[k] : lo[k])
					+ sp_to_real(off[k]));
			return plane_dist(p, c[0], c[1], c[2]);
		endfunction

		function void note(input item_t it);
			result_t r;
			int n;
			bit hit;
			n = (count > MAX_PLANES) ? MAX_PLANES : count;
			r.verdict = VERDICT_OUTSIDE;
			case (it.cmd)
				CMD_LOAD: begin
					if (it.plane_slot < MAX_PLANES) begin
						nx[it.plane_slot] = it.vec_x;
						ny[it.plane_slot] = it.vec_y;
						nz[it.plane_slot] = it.vec_z;
						distance[it.plane_slot] = it.scalar;
						signs[it.plane_slot] = {sp_to_real(it.vec_z) >= 0.0,
							sp_to_real(it.vec_y) >= 0.0, sp_to_real(it.vec_x) >= 0.0};
					end
				end
				CMD_FULL, CMD_QUICK: begin
					hit = 0;
					for (int p = 0; p < n && !hit; p++)
						if (mask[p] && corner_dist(p, it, 0) > sp_to_real(margin))
							hit = 1;
					if (hit)
						r.verdict = VERDICT_OUTSIDE;
					else if (it.cmd == CMD_QUICK)
						r.verdict = VERDICT_CROSS;
					else begin
						r.verdict = VERDICT_INSIDE;
						for (int p = 0; p < n; p++)
							if (mask[p] && corner_dist(p, it, 1) > 0.0)
								r.verdict = VERDICT_CROSS;
					end
				end
				CMD_SPHERE: begin
					r.verdict = VERDICT_CROSS;
					for (int p = 0; p < n; p++)
						if (mask[p] && !(plane_dist(p, sp_to_real(it.vec_x), sp_to_real(it.vec_y),
							sp_to_real(it.vec_z)) <= sp_to_real(it.scalar)))
							r.verdict = VERDICT_OUTSIDE;
				end
				CMD_UPDATE: begin
					for (int p = 0; p < n; p++)
						if (mask[p] && corner_dist(p, it, 1) <= 0.0)
							mask[p] = 1'b0;
				end
				CMD_ENABLE_ALL: mask = 6'h3F;
				default: ;
			endcase
			r.enable_bits = mask;
			awaited.push_back(r);
		endfunction

		function void check(input result_t got);
			result_t want;
			if (awaited.size() == 0) begin
				$error("result word with nothing awaited: %h", got);
				errors++;
				return;
			end
			want = awaited.pop_front();
			if (got.verdict !== want.verdict) begin
				$error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
				errors++;
			end
			if (got.enable_bits !== want.enable_bits) begin
				$error("enable_bits: expected %h, got %h", want.enable_bits, got.enable_bits);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic item_valid, item_stall, result_valid, result_stall;
	item_t item;
	result_t result;
	logic cfg_valid, cfg_ready;
	logic [0:0] cfg_index;
	logic [31:0] cfg_data;
	int idle_pct, stall_pct, quiet_cycles;
	culler_scoreboard book;

	frustum_box_sphere_culler DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Receiver side, result checking and the watchdog.
	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < stall_pct);
		if (result_valid && !result_stall)
			book.check(result);
		if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
			(cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else if (arst_n) begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	function automatic logic [31:0] rand_sp(input real lo, input real hi);
		if ($urandom_range(99) < 8)
			return $urandom;
		return real_to_sp(lo + (hi - lo) * (real'($urandom) / 4294967296.0));
	endfunction

	function automatic item_t make_item(input logic [2:0] cmd);
		item_t it;
		real cx, cy, cz;
		it.cmd = cmd;
		it.plane_slot = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 6))
			: 3'($urandom_range(5));
		cx = $urandom_range(400) - 200.0;
		cy = $urandom_range(400) - 200.0;
		cz = $urandom_range(400) - 200.0;
		it.box_min_x = rand_sp(cx - 30.0, cx);
		it.box_min_y = rand_sp(cy - 30.0, cy);
		it.box_min_z = rand_sp(cz - 30.0, cz);
		it.box_max_x = rand_sp(cx, cx + 30.0);
		it.box_max_y = rand_sp(cy, cy + 30.0);
		it.box_max_z = rand_sp(cz, cz + 30.0);
		if (cmd == CMD_LOAD) begin
			it.vec_x = rand_sp(-1.0, 1.0);
			it.vec_y = rand_sp(-1.0, 1.0);
			it.vec_z = rand_sp(-1.0, 1.0);
			it.scalar = rand_sp(-250.0, 250.0);
		end else begin
			it.vec_x = rand_sp(-60.0, 60.0);
			it.vec_y = rand_sp(-60.0, 60.0);
			it.vec_z = rand_sp(-60.0, 60.0);
			it.scalar = rand_sp(0.0, 150.0);
		end
		return it;
	endfunction

	task automatic send_word(input item_t it);
		item <= it;
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall);
		book.note(it);
		if ($urandom_range(99) < idle_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (book.awaited.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] data);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		book.set_reg(idx, data);
	endtask

	// Plane load into a given slot with a given normal and distance.
	task automatic load_plane(input int slot, input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z, input logic [31:0] d);
		item_t it;
		it = make_item(CMD_LOAD);
		it.plane_slot = 3'(slot);
		it.vec_x = x;
		it.vec_y = y;
		it.vec_z = z;
		it.scalar = d;
		send_word(it);
	endtask

	task automatic box_word(input logic [2:0] cmd, input real lo, input real hi);
		item_t it;
		it = make_item(cmd);
		it.box_min_x = real_to_sp(lo);
		it.box_min_y = real_to_sp(lo);
		it.box_min_z = real_to_sp(lo);
		it.box_max_x = real_to_sp(hi);
		it.box_max_y = real_to_sp(hi);
		it.box_max_z = real_to_sp(hi);
		it.vec_x = FP_ZERO;
		it.vec_y = 32'h8000_0000;
		it.vec_z = FP_ZERO;
		it.scalar = real_to_sp(hi);
		send_word(it);
	endtask

	initial begin
		item_t it;
		logic [2:0] cmd;
		book = new();
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PLANE_COUNT;
		cfg_data = '0;
		idle_pct = 0;
		stall_pct = 0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With no planes in use every test passes without touching the table.
		write_reg(CFG_PLANE_COUNT, 32'd0);
		for (int c = 1; c <= 4; c++)
			send_word(make_item(3'(c)));
		it = make_item(CMD_SPARE_A);
		send_word(it);
		it = make_item(CMD_SPARE_B);
		send_word(it);

		// A cube of unit-normal planes at +-100, one plane with a negative zero normal
		// component and one with a NaN component.
		load_plane(0, 32'h3F80_0000, FP_ZERO, FP_ZERO, real_to_sp(100.0));
		load_plane(1, 32'hBF80_0000, FP_ZERO, FP_ZERO, real_to_sp(100.0));
		load_plane(2, FP_ZERO, 32'h3F80_0000, 32'h8000_0000, real_to_sp(100.0));
		load_plane(3, FP_ZERO, 32'hBF80_0000, FP_ZERO, real_to_sp(100.0));
		load_plane(4, FP_ZERO, FP_ZERO, 32'h3F80_0000, real_to_sp(100.0));
		load_plane(5, FP_QNAN, FP_ZERO, 32'hBF80_0000, real_to_sp(100.0));
		load_plane(6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		load_plane(7, FP_ZERO, FP_ZERO, FP_ZERO, FP_ZERO);
		write_reg(CFG_PLANE_COUNT, 32'd7);
		box_word(CMD_FULL, -10.0, 10.0);
		box_word(CMD_FULL, 90.0, 120.0);
		box_word(CMD_QUICK, 300.0, 400.0);
		box_word(CMD_SPHERE, -5.0, 5.0);
		box_word(CMD_SPHERE, 150.0, 20.0);
		box_word(CMD_UPDATE, -10.0, 10.0);
		box_word(CMD_FULL, -10.0, 10.0);
		box_word(CMD_ENABLE_ALL, 0.0, 0.0);
		it = '1;
		it.cmd = CMD_FULL;
		send_word(it);
		it = '0;
		it.cmd = CMD_QUICK;
		send_word(it);

		// Random phases: none, sender idle, receiver stalling, both a little.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: write_reg(CFG_OUTSIDE_MARGIN, MARGIN_RESET);
				1: write_reg(CFG_OUTSIDE_MARGIN, FP_ZERO);
				2: write_reg(CFG_OUTSIDE_MARGIN, 32'hFFFF_FFFF);
				default: write_reg(CFG_OUTSIDE_MARGIN, $urandom);
			endcase
			write_reg(CFG_PLANE_COUNT, (ph == 2) ? 32'd3 : 32'($urandom_range(7)));
			idle_pct = (ph == 1) ? 62 : (ph == 3) ? 8 : 0;
			stall_pct = (ph == 2) ? 62 : (ph == 3) ? 8 : 0;
			for (int n = 0; n < 160; n++) begin
				case ($urandom_range(19))
					0, 1, 2: cmd = CMD_LOAD;
					3, 4, 5, 6: cmd = CMD_FULL;
					7, 8, 9: cmd = CMD_QUICK;
					10, 11, 12, 13: cmd = CMD_SPHERE;
					14, 15: cmd = CMD_UPDATE;
					16, 17: cmd = CMD_ENABLE_ALL;
					default: cmd = 3'($urandom_range(7));
				endcase
				send_word(make_item(cmd));
				if (ph == 1 && n == 80)
					drain();
			end
			if (ph == 1)
				write_reg(CFG_PLANE_COUNT, 32'd6);
		end

		drain();
		stall_pct = 0;
		repeat (40) @(posedge clk);
		if (book.errors == 0 && book.awaited.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
